// ----- design/pixel_window_level_mapper_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pixel window/level mapper
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_WINDOW_LEVEL_MAPPER_CORE_ASSERT_SVH
`define PIXEL_WINDOW_LEVEL_MAPPER_CORE_ASSERT_SVH

// Implication checked at every rising edge, off while in reset.
`define PWLM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwlm implication check failed");

// Condition that must hold at every rising edge out of reset.
`define PWLM_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pwlm invariant check failed");

`endif

// ----- design/pwlm_pkg.sv -----
// ----------------------------------------------------------------------------
// pwlm_pkg
// Types and constants shared by the window/level mapper and its checker.
// ----------------------------------------------------------------------------
package pwlm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int RAW_W       = 16;
    localparam logic [RAW_W-1:0] SAMPLE_MASK =
        RAW_W'((33'(1) << SAMPLE_BITS) - 33'(1));

    localparam int WIN_W  = 17;          // signed window bounds
    localparam int DIFF_W = 17;          // unsigned offset and window width
    localparam int PIX_W  = 8;
    localparam int QUO_W  = 8;           // quotient bits, one per divide stage
    localparam int NUM_W  = DIFF_W + 8;  // offset times 255

    // input reg, classify, scale, divide stages, output reg
    localparam int PIPE_DEPTH = 3 + QUO_W + 1;

    localparam logic [1:0] SPP_GREY = 2'd1;

    typedef enum logic [2:0] {
        REG_SPP         = 3'd0,
        REG_HIGH_BIT    = 3'd1,
        REG_BITS_STORED = 3'd2,
        REG_WIN_LOW     = 3'd3,
        REG_WIN_HIGH    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic             use_div;
        logic [PIX_W-1:0] pix;
        logic [NUM_W-1:0] rem;
    } div_stage_t;

endpackage

// ----- design/pixel_window_level_mapper_core.sv -----
// ----------------------------------------------------------------------------
// pixel_window_level_mapper_core
// Maps raw image samples to display bytes through a window/level transfer.
// ----------------------------------------------------------------------------
// One sample enters per clock (busy is always low). Its byte is driven on
// pixel_byte with result_valid from the output register. Bytes come out
// in order, with last_in copied to last_out. The depth of the pipeline is
// set by the restoring divider that computes (v - low) * 255 / (high - low):
// it yields one quotient bit per pipeline stage, eight stages, wrapped by an
// input register, a classify stage, a scale stage and the output register.
// The receiver cannot stall, so each result is shown for a single cycle and
// must be taken then. Write the configuration registers over the APB port
// only while no sample is in flight; register i sits at byte address 4*i.
// ----------------------------------------------------------------------------
module pixel_window_level_mapper_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample input
    input  logic        start,
    output logic        busy,
    input  logic [15:0] raw_sample,
    input  logic        last_in,
    // display byte output
    output logic        result_valid,
    output logic [7:0]  pixel_byte,
    output logic        last_out
);

    localparam int QW = pwlm_pkg::QUO_W;
    localparam int NW = pwlm_pkg::NUM_W;
    localparam int DW = pwlm_pkg::DIFF_W;
    localparam int PW = pwlm_pkg::PIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]         spp_reg;
    logic [3:0]         high_bit_reg;
    logic [4:0]         bits_stored_reg;
    logic signed [16:0] window_low_reg;
    logic signed [16:0] window_high_reg;

    logic               cfg_wr;
    pwlm_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = pwlm_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg         <= 2'd1;
            high_bit_reg    <= 4'd11;
            bits_stored_reg <= 5'd12;
            window_low_reg  <= 17'sd0;
            window_high_reg <= 17'sd4095;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                pwlm_pkg::REG_SPP:         spp_reg         <= pwdata[1:0];
                pwlm_pkg::REG_HIGH_BIT:    high_bit_reg    <= pwdata[3:0];
                pwlm_pkg::REG_BITS_STORED: bits_stored_reg <= pwdata[4:0];
                pwlm_pkg::REG_WIN_LOW:     window_low_reg  <= $signed(pwdata[16:0]);
                pwlm_pkg::REG_WIN_HIGH:    window_high_reg <= $signed(pwdata[16:0]);
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            pwlm_pkg::REG_SPP:         prdata = {30'd0, spp_reg};
            pwlm_pkg::REG_HIGH_BIT:    prdata = {28'd0, high_bit_reg};
            pwlm_pkg::REG_BITS_STORED: prdata = {27'd0, bits_stored_reg};
            pwlm_pkg::REG_WIN_LOW:     prdata = {15'd0, window_low_reg};
            pwlm_pkg::REG_WIN_HIGH:    prdata = {15'd0, window_high_reg};
            default:                   prdata = '0;
        endcase
    end

    // Values derived from the configuration. They are registered from the
    // configuration registers, before an item reaches the stages that use them.
    logic              win_en_reg;
    logic [DW-1:0]     den_reg;
    logic signed [17:0] den_full;

    assign den_full = $signed({window_high_reg[16], window_high_reg})
                    - $signed({window_low_reg[16], window_low_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // match the register reset values: grey, window 0..4095
            win_en_reg <= 1'b1;
            den_reg    <= 17'd4095;
        end
        else
        begin
            win_en_reg <= (spp_reg == pwlm_pkg::SPP_GREY)
                          && (window_low_reg != window_high_reg);
            den_reg    <= den_full[DW-1:0];
        end
    end

    // The block never holds off the source.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: align the sample (drop unused low bits)
    // ------------------------------------------------------------------
    logic signed [6:0] shift_s;
    logic [4:0]        shift_amt;
    logic [15:0]       v_next;
    logic              accept;

    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic [15:0]       s1_v_reg;

    assign accept    = start && !busy;
    assign shift_s   = $signed({3'b000, high_bit_reg}) + 7'sd1
                     - $signed({2'b00, bits_stored_reg});
    // saturate a negative shift to zero; the largest shift is 16
    assign shift_amt = shift_s[6] ? 5'd0 : shift_s[4:0];
    assign v_next    = (raw_sample & pwlm_pkg::SAMPLE_MASK) >> shift_amt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= last_in;
        s1_v_reg    <= v_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: classify against the window, form the offset from low
    // ------------------------------------------------------------------
    logic signed [17:0] sv;
    logic signed [17:0] lo_ext;
    logic signed [17:0] hi_ext;
    logic signed [17:0] off_full;
    logic               below;
    logic               above;
    logic               use_div_next;
    logic [PW-1:0]      pix_next;

    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic               s2_use_div_reg;
    logic [PW-1:0]      s2_pix_reg;
    logic [DW-1:0]      s2_off_reg;

    assign sv       = $signed({2'b00, s1_v_reg});
    assign lo_ext   = $signed({window_low_reg[16], window_low_reg});
    assign hi_ext   = $signed({window_high_reg[16], window_high_reg});
    assign off_full = sv - lo_ext;
    assign below    = sv < lo_ext;
    assign above    = sv > hi_ext;

    always_comb
    begin
        use_div_next = 1'b0;
        if (!win_en_reg)
            pix_next = s1_v_reg[PW-1:0];   // pass the low byte through
        else if (below)
            pix_next = '0;
        else if (above)
            pix_next = '1;
        else
        begin
            pix_next     = '0;             // quotient bits get set later
            use_div_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg    <= s1_last_reg;
        s2_use_div_reg <= use_div_next;
        s2_pix_reg     <= pix_next;
        s2_off_reg     <= off_full[DW-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 3: scale the offset by 255 as (off << 8) - off
    // ------------------------------------------------------------------
    pwlm_pkg::div_stage_t div_reg  [0:QW];
    pwlm_pkg::div_stage_t div_next [0:QW-1];
    pwlm_pkg::div_stage_t scale_next;

    always_comb
    begin
        scale_next.valid   = s2_valid_reg;
        scale_next.last    = s2_last_reg;
        scale_next.use_div = s2_use_div_reg;
        scale_next.pix     = s2_pix_reg;
        scale_next.rem     = {s2_off_reg, 8'd0} - NW'(s2_off_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_reg[0] <= '0;
        else
            div_reg[0] <= scale_next;
    end

    // ------------------------------------------------------------------
    // Stages 4..11: restoring divide, one quotient bit per stage, MSB first.
    // The scaled offset never exceeds 255 times the window width, so eight
    // bits cover the quotient.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int BIT = QW - 1 - k;

        logic [NW-1:0] trial;
        logic          take;

        assign trial = NW'(den_reg) << BIT;
        assign take  = div_reg[k].use_div && (div_reg[k].rem >= trial);

        always_comb
        begin
            div_next[k] = div_reg[k];
            if (take)
            begin
                div_next[k].rem      = div_reg[k].rem - trial;
                div_next[k].pix[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_reg[k+1] <= '0;
            else
                div_reg[k+1] <= div_next[k];
        end
    end

    // ------------------------------------------------------------------
    // Output register: one-cycle result strobe
    // ------------------------------------------------------------------
    logic          result_valid_reg;
    logic [PW-1:0] pixel_byte_reg;
    logic          last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= div_reg[QW].valid;
    end

    always_ff @(posedge clk)
    begin
        pixel_byte_reg <= div_reg[QW].pix;
        last_out_reg   <= div_reg[QW].last;
    end

    assign result_valid = result_valid_reg;
    assign pixel_byte   = pixel_byte_reg;
    assign last_out     = last_out_reg;

endmodule

// ----- design/pwlm_checker.sv -----
// ----------------------------------------------------------------------------
// pwlm_checker
// Port-level timing checks for the window/level mapper, bound to the core.
// ----------------------------------------------------------------------------
`include "pixel_window_level_mapper_core_assert.svh"

module pwlm_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_in,
    input logic result_valid,
    input logic last_out
);

    localparam int LAT = pwlm_pkg::PIPE_DEPTH;

    // every accepted sample yields its byte after the fixed latency
    `PWLM_ASSERT_IMP(a_result_follows, clk, rst_n, start && !busy, ##LAT result_valid)
    // no result without a transfer the fixed latency earlier
    `PWLM_ASSERT_IMP(a_no_spurious, clk, rst_n, result_valid, $past(start && !busy, LAT))
    // the end-of-image mark travels with its sample
    `PWLM_ASSERT_IMP(a_last_kept, clk, rst_n, result_valid, last_out == $past(last_in, LAT))
    // the source is never held off
    `PWLM_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)

endmodule

bind pixel_window_level_mapper_core pwlm_checker u_pwlm_checker (.*);
